FILE: rtl/ctce_pkg.sv
// Shared types, codes and constants of the capture transfer command engine.
`default_nettype none

package ctce_pkg;

   localparam int STORE_DEPTH_DEFAULT = 65536;

   localparam int SIZE_W   = 17;
   localparam int INFO_W   = 32;
   localparam int REMAIN_W = 31;
   localparam int ADDR_W   = 16;
   localparam int BYTE_W   = 8;

   localparam logic [SIZE_W-1:0] MAX_SIZE_RESET  = 17'd65536;
   localparam logic [SIZE_W-1:0] CMD_LIMIT_RESET = 17'd100000;

   typedef enum logic [1:0] {
      OPC_COMMAND = 2'd0,
      OPC_DATA    = 2'd1,
      OPC_ABORT   = 2'd2,
      OPC_READ    = 2'd3
   } opcode_type;

   localparam logic [7:0] CMD_START     = 8'd1;
   localparam logic [7:0] CMD_END       = 8'd2;
   localparam logic [7:0] CMD_SEGMENT   = 8'd3;
   localparam logic [7:0] CMD_SEEK_ZERO = 8'd4;
   localparam logic [7:0] CMD_SEEK_POS  = 8'd5;
   localparam logic [7:0] CMD_SEEK_SIZE = 8'd6;

   typedef enum logic [3:0] {
      ST_ACCEPTED    = 4'd0,
      ST_FINISHED    = 4'd1,
      ST_CORRUPT     = 4'd2,
      ST_BAD_PARAM   = 4'd3,
      ST_LIMIT       = 4'd4,
      ST_UNSUPPORTED = 4'd5,
      ST_CANCELLED   = 4'd6,
      ST_TIMEOUT     = 4'd7,
      ST_CLOSED      = 4'd8
   } status_type;

   typedef enum logic [1:0] {
      PH_START   = 2'd0,
      PH_RUN     = 2'd1,
      PH_SEGMENT = 2'd2,
      PH_CLOSED  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      CS_IDLE = 2'd0,
      CS_EXEC = 2'd1,
      CS_FILL = 2'd2,
      CS_READ = 2'd3
   } ctrl_state_type;

   localparam int CSR_INDEX_W = 1;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_SIZE  = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CMD_LIMIT = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic commit;
      logic fill_step;
      logic read_issue;
      logic read_commit;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_read;
      logic need_fill;
      logic out_free;
   } dp_status_type;

endpackage

`default_nettype wire

FILE: rtl/ctce_if.sv
// Valid/ready channel interfaces for request and response beats.
`default_nettype none

interface ctce_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         opcode;
   logic [7:0]                         operation;
   logic signed [ctce_pkg::INFO_W-1:0] info;
   logic [ctce_pkg::BYTE_W-1:0]        data_byte;
   logic                               abort_is_timeout;
   logic [ctce_pkg::ADDR_W-1:0]        read_address;

   modport source (output valid, opcode, operation, info, data_byte, abort_is_timeout,
                   read_address, input ready);
   modport sink (input valid, opcode, operation, info, data_byte, abort_is_timeout,
                 read_address, output ready);
endinterface

interface ctce_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [3:0]                  status;
   logic [ctce_pkg::BYTE_W-1:0] read_data;
   logic [ctce_pkg::SIZE_W-1:0] file_size;
   logic [ctce_pkg::SIZE_W-1:0] write_offset;

   modport source (output valid, status, read_data, file_size, write_offset, input ready);
   modport sink (input valid, status, read_data, file_size, write_offset, output ready);
endinterface

`default_nettype wire

FILE: rtl/ctce_ctrl.sv
// Controller state machine that sequences accept, execute, gap fill and read.
`default_nettype none

module ctce_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire ctce_pkg::dp_status_type dp_status,
   output ctce_pkg::dp_cmd_type         dp_cmd
);
   import ctce_pkg::*;

   ctrl_state_type state_ff;
   ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= CS_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      dp_cmd    = '0;
      unique case (state_ff)
         CS_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               dp_cmd.capture = 1'b1;
               state_in       = CS_EXEC;
            end
         end
         CS_EXEC: begin
            priority if (dp_status.is_read) begin
               dp_cmd.read_issue = 1'b1;
               state_in          = CS_READ;
            end else if (dp_status.need_fill) begin
               state_in = CS_FILL;
            end else if (dp_status.out_free) begin
               dp_cmd.commit = 1'b1;
               state_in      = CS_IDLE;
            end else begin
               // The response register still holds the previous beat.
               state_in = CS_EXEC;
            end
         end
         CS_FILL: begin
            // One zero byte per cycle until the gap up to the write position is closed.
            if (dp_status.need_fill) begin
               dp_cmd.fill_step = 1'b1;
            end else begin
               state_in = CS_EXEC;
            end
         end
         CS_READ: begin
            if (dp_status.out_free) begin
               dp_cmd.read_commit = 1'b1;
               state_in           = CS_IDLE;
            end
         end
         default: begin
            state_in = CS_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: rtl/ctce_datapath.sv
// Datapath: run state, command evaluation, file store and response register.
`default_nettype none

module ctce_datapath #(
   parameter int STORE_DEPTH = ctce_pkg::STORE_DEPTH_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic [1:0]                          req_opcode,
   input  wire logic [7:0]                          req_operation,
   input  wire logic signed [ctce_pkg::INFO_W-1:0]  req_info,
   input  wire logic [ctce_pkg::BYTE_W-1:0]         req_data_byte,
   input  wire logic                                req_abort_is_timeout,
   input  wire logic [ctce_pkg::ADDR_W-1:0]         req_read_address,
   input  wire logic                                csr_write_enable,
   input  wire logic [ctce_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [ctce_pkg::SIZE_W-1:0]         csr_write_data,
   input  wire ctce_pkg::dp_cmd_type                dp_cmd,
   output ctce_pkg::dp_status_type                  dp_status,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [3:0]                               rsp_status,
   output logic [ctce_pkg::BYTE_W-1:0]              rsp_read_data,
   output logic [ctce_pkg::SIZE_W-1:0]              rsp_file_size,
   output logic [ctce_pkg::SIZE_W-1:0]              rsp_write_offset
);
   import ctce_pkg::*;

   localparam int AW = $clog2(STORE_DEPTH);

   // Configuration registers.
   logic [SIZE_W-1:0] max_size_ff;
   logic [SIZE_W-1:0] cmd_limit_ff;

   // Captured request beat.
   opcode_type                item_opcode_ff;
   logic [7:0]                item_operation_ff;
   logic signed [INFO_W-1:0]  item_info_ff;
   logic [BYTE_W-1:0]         item_byte_ff;
   logic                      item_timeout_ff;
   logic [ADDR_W-1:0]         item_address_ff;

   // Run state.
   phase_type           phase_ff;
   logic [SIZE_W-1:0]   count_ff;
   logic [REMAIN_W-1:0] remain_ff;
   logic [SIZE_W-1:0]   pos_ff;
   logic [SIZE_W-1:0]   extent_ff;

   phase_type           phase_in;
   logic [SIZE_W-1:0]   count_in;
   logic [REMAIN_W-1:0] remain_in;
   logic [SIZE_W-1:0]   pos_in;
   logic [SIZE_W-1:0]   extent_in;
   status_type          status_in;
   logic                data_write;

   // Response register.
   logic              rsp_valid_ff;
   logic [3:0]        rsp_status_ff;
   logic [BYTE_W-1:0] rsp_read_data_ff;
   logic [SIZE_W-1:0] rsp_file_size_ff;
   logic [SIZE_W-1:0] rsp_write_offset_ff;

   // File store.
   logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
   logic [BYTE_W-1:0] rdata_ff;
   logic              mem_we;
   logic [AW-1:0]     mem_waddr;
   logic [BYTE_W-1:0] mem_wdata;

   logic [SIZE_W-1:0]   size_limit;
   logic                count_over;
   logic [SIZE_W-1:0]   seek_base;
   logic signed [33:0]  seek_dest;
   logic                seek_ok;
   logic [SIZE_W:0]     pos_plus;
   logic                write_over;
   logic                read_hit;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_size_ff  <= MAX_SIZE_RESET;
         cmd_limit_ff <= CMD_LIMIT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_MAX_SIZE:  max_size_ff  <= csr_write_data;
            CSR_CMD_LIMIT: cmd_limit_ff <= csr_write_data;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.capture) begin
         item_opcode_ff    <= opcode_type'(req_opcode);
         item_operation_ff <= req_operation;
         item_info_ff      <= req_info;
         item_byte_ff      <= req_data_byte;
         item_timeout_ff   <= req_abort_is_timeout;
         item_address_ff   <= req_read_address;
      end
   end

   always_comb begin
      size_limit = (int'(max_size_ff) < STORE_DEPTH) ? max_size_ff : SIZE_W'(STORE_DEPTH);
      count_over = ({1'b0, count_ff} + 18'd1) > {1'b0, cmd_limit_ff};
      priority case (item_operation_ff)
         CMD_SEEK_ZERO: seek_base = '0;
         CMD_SEEK_POS:  seek_base = pos_ff;
         default:       seek_base = extent_ff;
      endcase
      seek_dest  = $signed({17'd0, seek_base}) + 34'(item_info_ff);
      seek_ok    = !seek_dest[33] && (seek_dest <= $signed({17'd0, size_limit}));
      pos_plus   = {1'b0, pos_ff} + 18'd1;
      write_over = pos_plus > {1'b0, size_limit};
      read_hit   = {1'b0, item_address_ff} < extent_ff;
   end

   // Outcome of the captured beat, applied on commit.
   always_comb begin
      phase_in   = phase_ff;
      count_in   = count_ff;
      remain_in  = remain_ff;
      pos_in     = pos_ff;
      extent_in  = extent_ff;
      status_in  = ST_ACCEPTED;
      data_write = 1'b0;
      priority if (item_opcode_ff == OPC_READ) begin
         status_in = ST_ACCEPTED;
      end else if (phase_ff == PH_CLOSED) begin
         status_in = ST_CLOSED;
      end else begin
         unique case (item_opcode_ff)
            OPC_COMMAND: begin
               if (count_over) begin
                  status_in = ST_LIMIT;
               end else begin
                  count_in = count_ff + 17'd1;
                  priority if (phase_ff == PH_SEGMENT) begin
                     status_in = ST_CORRUPT;
                  end else if (phase_ff == PH_START) begin
                     if (item_operation_ff == CMD_START) begin
                        phase_in = PH_RUN;
                     end else begin
                        status_in = ST_CORRUPT;
                     end
                  end else begin
                     unique case (item_operation_ff)
                        CMD_START: status_in = ST_CORRUPT;
                        CMD_END: begin
                           status_in = (extent_ff != '0) ? ST_FINISHED : ST_CORRUPT;
                        end
                        CMD_SEGMENT: begin
                           if (item_info_ff == '0 || item_info_ff[INFO_W-1]) begin
                              status_in = ST_CORRUPT;
                           end else begin
                              remain_in = item_info_ff[REMAIN_W-1:0];
                              phase_in  = PH_SEGMENT;
                           end
                        end
                        CMD_SEEK_ZERO, CMD_SEEK_POS, CMD_SEEK_SIZE: begin
                           if (seek_ok) begin
                              pos_in = seek_dest[SIZE_W-1:0];
                           end else begin
                              status_in = ST_BAD_PARAM;
                           end
                        end
                        default: status_in = ST_UNSUPPORTED;
                     endcase
                  end
               end
            end
            OPC_DATA: begin
               priority if (phase_ff != PH_SEGMENT) begin
                  status_in = ST_CORRUPT;
               end else if (write_over) begin
                  status_in = ST_LIMIT;
               end else begin
                  data_write = 1'b1;
                  pos_in     = pos_plus[SIZE_W-1:0];
                  extent_in  = (pos_plus[SIZE_W-1:0] > extent_ff) ? pos_plus[SIZE_W-1:0]
                                                                  : extent_ff;
                  remain_in  = remain_ff - 31'd1;
                  if (remain_ff == 31'd1) begin
                     phase_in = PH_RUN;
                  end
               end
            end
            OPC_ABORT: begin
               status_in = item_timeout_ff ? ST_TIMEOUT : ST_CANCELLED;
            end
            default: begin
               status_in = ST_ACCEPTED;
            end
         endcase
         // Every error, the end command and every abort close the run.
         if (status_in != ST_ACCEPTED) begin
            phase_in  = PH_CLOSED;
            remain_in = '0;
         end
      end
   end

   always_comb begin
      dp_status.is_read   = (item_opcode_ff == OPC_READ);
      dp_status.need_fill = (item_opcode_ff == OPC_DATA) && (phase_ff == PH_SEGMENT) &&
                            !write_over && (extent_ff < pos_ff);
      dp_status.out_free  = !rsp_valid_ff || rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_START;
         count_ff  <= '0;
         remain_ff <= '0;
         pos_ff    <= '0;
         extent_ff <= '0;
      end else if (dp_cmd.commit) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         remain_ff <= remain_in;
         pos_ff    <= pos_in;
         extent_ff <= extent_in;
      end else if (dp_cmd.fill_step) begin
         // The gap below the write position grows the file one zero byte at a time.
         extent_ff <= extent_ff + 17'd1;
      end
   end

   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = AW'(pos_ff);
      mem_wdata = item_byte_ff;
      if (dp_cmd.commit && data_write) begin
         mem_we = 1'b1;
      end else if (dp_cmd.fill_step) begin
         mem_we    = 1'b1;
         mem_waddr = AW'(extent_ff);
         mem_wdata = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         store_mem[mem_waddr] <= mem_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.read_issue) begin
         rdata_ff <= store_mem[AW'(item_address_ff)];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (dp_cmd.commit || dp_cmd.read_commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (dp_cmd.commit) begin
         rsp_status_ff       <= status_in;
         rsp_read_data_ff    <= '0;
         rsp_file_size_ff    <= extent_in;
         rsp_write_offset_ff <= pos_in;
      end else if (dp_cmd.read_commit) begin
         rsp_status_ff       <= ST_ACCEPTED;
         rsp_read_data_ff    <= read_hit ? rdata_ff : '0;
         rsp_file_size_ff    <= extent_ff;
         rsp_write_offset_ff <= pos_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_read_data    = rsp_read_data_ff;
   assign rsp_file_size    = rsp_file_size_ff;
   assign rsp_write_offset = rsp_write_offset_ff;

endmodule

`default_nettype wire

FILE: rtl/capture_transfer_command_engine_core.sv
// Top level of the capture transfer command engine.
//
//   Channel  Direction  Handshake               Beat contents
//   req_bus  in         valid/ready             opcode, operation, info, data_byte,
//                                               abort_is_timeout, read_address
//   rsp_bus  out        valid/ready             status, read_data, file_size, write_offset
//   csr_*    in         csr_write_enable only   csr_index, csr_write_data
//
// A command, abort or data beat passes through accept and then execute; a read beat
// adds a read step after execute, set by the registered read port of the file store.
// A data beat after a seek beyond the file end first enters a fill state that writes
// the gap one zero byte per cycle and then returns to execute, since the store has a
// single write port.
// Reset is synchronous; the store needs no clearing pass, as bytes above the file
// size read as zero. A stalled response holds in its register while the next
// request beat is already taken; execution then waits until that register frees.
`default_nettype none

module capture_transfer_command_engine_core #(
   parameter int STORE_DEPTH = ctce_pkg::STORE_DEPTH_DEFAULT
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   ctce_req_if.sink                                    req_bus,
   ctce_rsp_if.source                                  rsp_bus,
   input  wire logic                                   csr_write_enable,
   input  wire logic [ctce_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  wire logic [ctce_pkg::SIZE_W-1:0]            csr_write_data
);
   import ctce_pkg::*;

   dp_cmd_type    dp_cmd;
   dp_status_type dp_status;
   logic          req_ready;

   assign req_bus.ready = req_ready;

   ctce_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_ready),
      .dp_status (dp_status),
      .dp_cmd    (dp_cmd)
   );

   ctce_datapath #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_datapath (
      .clock                (clock),
      .reset                (reset),
      .req_opcode           (req_bus.opcode),
      .req_operation        (req_bus.operation),
      .req_info             (req_bus.info),
      .req_data_byte        (req_bus.data_byte),
      .req_abort_is_timeout (req_bus.abort_is_timeout),
      .req_read_address     (req_bus.read_address),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_write_data       (csr_write_data),
      .dp_cmd               (dp_cmd),
      .dp_status            (dp_status),
      .rsp_valid            (rsp_bus.valid),
      .rsp_ready            (rsp_bus.ready),
      .rsp_status           (rsp_bus.status),
      .rsp_read_data        (rsp_bus.read_data),
      .rsp_file_size        (rsp_bus.file_size),
      .rsp_write_offset     (rsp_bus.write_offset)
   );

endmodule

`default_nettype wire
